// ===== rtl/core/rtm_pkg.sv =====
// Package for the resampling tone mixer: field widths, command and register
// codes, and reset values shared by the channel interfaces and the top level.
// It depends on nothing else.
`default_nettype none

package rtm_pkg;

	localparam int CMD_W        = 2;
	localparam int SAMPLE_W     = 16;
	localparam int ADDR_FIELD_W = 16;
	localparam int LEN_W        = 17;
	localparam int RATE_W       = 18;
	localparam int GAIN_W       = 16;
	localparam int ACT_W        = 3;

	localparam int SAMPLE_WORDS = 65536;
	localparam int MEM_ADDR_W   = $clog2(SAMPLE_WORDS);
	localparam int CHANNELS     = 4;
	localparam int CH_W         = $clog2(CHANNELS);

	localparam int FRAC_BITS    = 16;
	localparam int PHASE_W      = 33;
	localparam int STEP_W       = 32;

	// The step numerator is (rate << 16) + divisor / 2, which needs 35 bits.
	localparam int DIV_STEPS    = RATE_W + FRAC_BITS + 1;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = RATE_W;

	localparam logic [RATE_W-1:0] DEFAULT_RATE   = 18'd48000;
	localparam logic [STEP_W-1:0] RESET_STEP     = 32'd65536;
	localparam logic [GAIN_W-1:0] RESET_GAIN     = 16'd4096;
	localparam logic [ACT_W-1:0]  RESET_CHANNELS = 3'd4;

	typedef enum logic [CMD_W-1:0] {
		CMD_FRAME = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_START = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OUT_RATE = 2'd0,
		CFG_GAIN     = 2'd1,
		CFG_CHANNELS = 2'd2
	} cfg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/core/rtm_channels.sv =====
// Valid/ready channel interfaces of the resampling tone mixer: one for the
// command beats going in and one for the mixed frames coming out.
// Widths come from rtm_pkg.
`default_nettype none

interface rtm_item_if;
	logic                                      valid;
	logic                                      ready;
	logic [rtm_pkg::CMD_W-1:0]                 cmd;
	logic signed [rtm_pkg::SAMPLE_W-1:0]       audio_in_0;
	logic signed [rtm_pkg::SAMPLE_W-1:0]       audio_in_1;
	logic signed [rtm_pkg::SAMPLE_W-1:0]       audio_in_2;
	logic signed [rtm_pkg::SAMPLE_W-1:0]       audio_in_3;
	logic [rtm_pkg::ADDR_FIELD_W-1:0]          load_addr;
	logic signed [rtm_pkg::SAMPLE_W-1:0]       load_data;
	logic [rtm_pkg::ADDR_FIELD_W-1:0]          tone_base;
	logic [rtm_pkg::LEN_W-1:0]                 tone_length;
	logic [rtm_pkg::RATE_W-1:0]                tone_rate_hz;

	modport source (
		output valid, cmd, audio_in_0, audio_in_1, audio_in_2, audio_in_3,
		output load_addr, load_data, tone_base, tone_length, tone_rate_hz,
		input  ready
	);
	modport sink (
		input  valid, cmd, audio_in_0, audio_in_1, audio_in_2, audio_in_3,
		input  load_addr, load_data, tone_base, tone_length, tone_rate_hz,
		output ready
	);
endinterface

interface rtm_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [rtm_pkg::SAMPLE_W-1:0] audio_out_0;
	logic signed [rtm_pkg::SAMPLE_W-1:0] audio_out_1;
	logic signed [rtm_pkg::SAMPLE_W-1:0] audio_out_2;
	logic signed [rtm_pkg::SAMPLE_W-1:0] audio_out_3;
	logic                                tone_active;

	modport source (
		output valid, audio_out_0, audio_out_1, audio_out_2, audio_out_3, tone_active,
		input  ready
	);
	modport sink (
		input  valid, audio_out_0, audio_out_1, audio_out_2, audio_out_3, tone_active,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/resampling_tone_mixer_top.sv =====
// Top level of the resampling tone mixer: sequencer, sample memory, step
// divider and shared multiplier. Depends on rtm_pkg and the interfaces in
// rtm_channels.sv.
// A load beat writes the sample memory and leaves the block ready. A frame beat
// with a tone walks RD1 to RND, then the MIX states and OUT; a frame with no tone
// mixed goes straight to MIX. A start beat occupies the block in DIV and STEP, the
// one-bit-per-cycle step divider. One beat at a time: the next beat is taken once
// the sequencer is back in IDLE, which OUT delays while the output register still
// holds an untaken frame.
// Reset: arst_n clears the sequencer, the tone state and the configuration to
// their reset values at once; the sample memory is not cleared and no pass runs.
`default_nettype none

module resampling_tone_mixer_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wen,
	input  wire logic [rtm_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [rtm_pkg::CFG_DATA_W-1:0]   cfg_data,
	rtm_item_if.sink                              item,
	rtm_result_if.source                          result
);

	// The sequencer. A frame with a tone walks RD1 (first sample back, second read),
	// MUL1 (slope times fraction), SUM (interpolated value), MUL2 (times gain),
	// RND (round to sample units), then MIX for each channel in turn and OUT, which
	// waits for the output register to be free; a frame without a tone goes straight
	// to MIX. A start runs DIV for every quotient bit and STEP to clamp the result.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_STEP,
		ST_RD1,
		ST_MUL1,
		ST_SUM,
		ST_MUL2,
		ST_RND,
		ST_MIX,
		ST_OUT
	} state_t;

	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int TONE_W  = MUL_P_W - 28;
	localparam int MIX_W   = TONE_W + 1;

	state_t state_q;

	// Configuration.
	logic [rtm_pkg::RATE_W-1:0]  out_rate_q;
	logic [rtm_pkg::GAIN_W-1:0]  gain_q;
	logic [rtm_pkg::ACT_W-1:0]   active_q;

	// Tone state.
	logic [rtm_pkg::PHASE_W-1:0]      phase_q;
	logic [rtm_pkg::STEP_W-1:0]       step_q;
	logic [rtm_pkg::ADDR_FIELD_W-1:0] base_q;
	logic [rtm_pkg::LEN_W-1:0]        len_q;
	logic                             playing_q;
	logic                             mixed_q;
	logic                             next_ok_q;
	logic [rtm_pkg::CH_W-1:0]         ch_q;
	logic                             out_valid_q;

	// Divider.
	logic [rtm_pkg::DIV_STEPS-1:0] div_num_q;
	logic [rtm_pkg::RATE_W-1:0]    div_rem_q;
	logic [rtm_pkg::RATE_W-1:0]    div_den_q;
	logic [rtm_pkg::DIV_CNT_W-1:0] div_cnt_q;

	// Datapath payload.
	logic signed [rtm_pkg::SAMPLE_W-1:0] rd_q;
	logic signed [rtm_pkg::SAMPLE_W-1:0] s0_q;
	logic signed [MUL_P_W-1:0]           mul_q;
	logic signed [MUL_A_W-1:0]           interp_q;
	logic signed [TONE_W-1:0]            tone_q;
	logic signed [rtm_pkg::SAMPLE_W-1:0] audio_q [rtm_pkg::CHANNELS];
	logic signed [rtm_pkg::SAMPLE_W-1:0] res_q   [rtm_pkg::CHANNELS];
	logic signed [rtm_pkg::SAMPLE_W-1:0] out_q   [rtm_pkg::CHANNELS];
	logic                                out_act_q;

	logic signed [rtm_pkg::SAMPLE_W-1:0] sample_mem [rtm_pkg::SAMPLE_WORDS];

	logic                               accept;
	logic                               out_free;
	logic [rtm_pkg::LEN_W-1:0]          idx;
	logic [rtm_pkg::LEN_W:0]            idx_next;
	logic [rtm_pkg::LEN_W-1:0]          addr_sum;
	logic [rtm_pkg::MEM_ADDR_W-1:0]     rd_addr;
	logic [rtm_pkg::MEM_ADDR_W-1:0]     wr_addr;
	logic                               mem_we;
	logic [rtm_pkg::RATE_W-1:0]         src_rate;
	logic [rtm_pkg::RATE_W-1:0]         div_rate;
	logic [rtm_pkg::RATE_W:0]           div_trial;
	logic                               div_bit;
	logic [rtm_pkg::PHASE_W-1:0]        phase_adv;
	logic signed [rtm_pkg::SAMPLE_W:0]  slope;
	logic signed [rtm_pkg::SAMPLE_W-1:0] s1;
	logic signed [MUL_A_W-1:0]          mul_a;
	logic signed [MUL_B_W-1:0]          mul_b;
	logic signed [MUL_P_W-1:0]          mul_p;
	logic signed [MUL_P_W-1:0]          round_sum;
	logic signed [MIX_W-1:0]            mix_sum;
	logic signed [rtm_pkg::SAMPLE_W-1:0] mix_sat;
	logic                               ch_on;

	assign accept   = item.valid && item.ready;
	assign out_free = !out_valid_q || result.ready;

	// Sample index of the current phase and the one after it.
	assign idx      = phase_q[rtm_pkg::PHASE_W-1:rtm_pkg::FRAC_BITS];
	assign idx_next = {1'b0, idx} + {{rtm_pkg::LEN_W{1'b0}}, 1'b1};

	// Addresses wrap modulo the memory depth. In RD1 the second sample is read.
	always_comb begin
		if (state_q == ST_RD1) begin
			addr_sum = {1'b0, base_q} + idx_next[rtm_pkg::LEN_W-1:0];
		end else begin
			addr_sum = {1'b0, base_q} + idx;
		end
	end
	assign rd_addr = addr_sum[rtm_pkg::MEM_ADDR_W-1:0];
	assign wr_addr = item.load_addr[rtm_pkg::MEM_ADDR_W-1:0];
	assign mem_we  = accept && (item.cmd == rtm_pkg::CMD_LOAD);

	// A zero rate on either side stands for the default rate.
	assign src_rate = (item.tone_rate_hz == '0) ? rtm_pkg::DEFAULT_RATE : item.tone_rate_hz;
	assign div_rate = (out_rate_q == '0) ? rtm_pkg::DEFAULT_RATE : out_rate_q;

	// One restoring division step: shift in the next numerator bit and
	// subtract the divisor when it fits.
	assign div_trial = {div_rem_q, div_num_q[rtm_pkg::DIV_STEPS-1]};
	assign div_bit   = (div_trial >= {1'b0, div_den_q});

	assign phase_adv = phase_q + {1'b0, step_q};

	// Shared multiplier: slope times fraction in MUL1, value times gain
	// otherwise.
	assign s1    = next_ok_q ? rd_q : s0_q;
	assign slope = {s1[rtm_pkg::SAMPLE_W-1], s1} - {s0_q[rtm_pkg::SAMPLE_W-1], s0_q};
	always_comb begin
		if (state_q == ST_MUL1) begin
			mul_a = MUL_A_W'(slope);
			mul_b = {1'b0, phase_q[rtm_pkg::FRAC_BITS-1:0]};
		end else begin
			mul_a = interp_q;
			mul_b = {1'b0, gain_q};
		end
	end
	assign mul_p = mul_a * mul_b;

	// Round half up at the Q28 point, then floor by the arithmetic slice.
	assign round_sum = mul_q + MUL_P_W'(64'sd134217728);

	// Per-channel saturating add.
	assign ch_on   = mixed_q && ({1'b0, ch_q} < active_q);
	assign mix_sum = MIX_W'(audio_q[ch_q]) + (ch_on ? MIX_W'(tone_q) : '0);
	always_comb begin
		if (mix_sum > MIX_W'(32767)) begin
			mix_sat = 16'sh7fff;
		end else if (mix_sum < -MIX_W'(32768)) begin
			mix_sat = 16'sh8000;
		end else begin
			mix_sat = mix_sum[rtm_pkg::SAMPLE_W-1:0];
		end
	end

	// Sample memory with a registered read port; the reads of a frame are
	// issued on the accepting edge and in RD1.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			sample_mem[wr_addr] <= item.load_data;
		end
		rd_q <= sample_mem[rd_addr];
	end

	// Sequencer, tone state, configuration and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_rate_q  <= rtm_pkg::DEFAULT_RATE;
			gain_q      <= rtm_pkg::RESET_GAIN;
			active_q    <= rtm_pkg::RESET_CHANNELS;
			phase_q     <= '0;
			step_q      <= rtm_pkg::RESET_STEP;
			base_q      <= '0;
			len_q       <= '0;
			playing_q   <= 1'b0;
			mixed_q     <= 1'b0;
			next_ok_q   <= 1'b0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
			div_num_q   <= '0;
			div_rem_q   <= '0;
			div_den_q   <= '0;
			div_cnt_q   <= '0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_idx)
					rtm_pkg::CFG_OUT_RATE: out_rate_q <= cfg_data;
					rtm_pkg::CFG_GAIN:     gain_q     <= cfg_data[rtm_pkg::GAIN_W-1:0];
					rtm_pkg::CFG_CHANNELS: active_q   <= cfg_data[rtm_pkg::ACT_W-1:0];
					default: ;
				endcase
			end

			// The output register loads in OUT when it is free; otherwise a taken
			// frame empties it.
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					ch_q <= '0;
					if (accept) begin
						unique case (item.cmd)
							rtm_pkg::CMD_FRAME: begin
								if (playing_q && (len_q != '0) && (idx < len_q)) begin
									mixed_q <= 1'b1;
									state_q <= ST_RD1;
								end else begin
									playing_q <= 1'b0;
									phase_q   <= '0;
									mixed_q   <= 1'b0;
									state_q   <= ST_MIX;
								end
							end
							rtm_pkg::CMD_START: begin
								base_q    <= item.tone_base;
								len_q     <= item.tone_length;
								phase_q   <= '0;
								playing_q <= 1'b1;
								div_num_q <= {1'b0, src_rate, {rtm_pkg::FRAC_BITS{1'b0}}}
									+ rtm_pkg::DIV_STEPS'(div_rate >> 1);
								div_rem_q <= '0;
								div_den_q <= div_rate;
								div_cnt_q <= '0;
								state_q   <= ST_DIV;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					div_num_q <= {div_num_q[rtm_pkg::DIV_STEPS-2:0], div_bit};
					div_rem_q <= div_bit
						? rtm_pkg::RATE_W'(div_trial - {1'b0, div_den_q})
						: div_trial[rtm_pkg::RATE_W-1:0];
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == rtm_pkg::DIV_CNT_W'(rtm_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					// Clamp the quotient to 1 .. 0xFFFFFFFF.
					if (div_num_q == '0) begin
						step_q <= rtm_pkg::STEP_W'(1);
					end else if (div_num_q[rtm_pkg::DIV_STEPS-1:rtm_pkg::STEP_W] != '0) begin
						step_q <= '1;
					end else begin
						step_q <= div_num_q[rtm_pkg::STEP_W-1:0];
					end
					state_q <= ST_IDLE;
				end
				ST_RD1: begin
					next_ok_q <= (idx_next < {1'b0, len_q});
					state_q   <= ST_MUL1;
				end
				ST_MUL1: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					// The fraction has been used, so the phase may advance now.
					phase_q <= phase_adv;
					state_q <= ST_RND;
				end
				ST_RND: begin
					if (idx >= len_q) begin
						playing_q <= 1'b0;
					end
					ch_q    <= '0;
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					ch_q <= ch_q + 1'b1;
					if (ch_q == rtm_pkg::CH_W'(rtm_pkg::CHANNELS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers; they carry payload only and need no reset.
	always_ff @(posedge clk) begin
		if (accept && (item.cmd == rtm_pkg::CMD_FRAME)) begin
			audio_q[0] <= item.audio_in_0;
			audio_q[1] <= item.audio_in_1;
			audio_q[2] <= item.audio_in_2;
			audio_q[3] <= item.audio_in_3;
		end
		if (state_q == ST_RD1) begin
			s0_q <= rd_q;
		end
		if ((state_q == ST_MUL1) || (state_q == ST_MUL2)) begin
			mul_q <= mul_p;
		end
		if (state_q == ST_SUM) begin
			interp_q <= MUL_A_W'($signed({s0_q, {rtm_pkg::FRAC_BITS{1'b0}}}))
				+ mul_q[MUL_A_W-1:0];
		end
		if (state_q == ST_RND) begin
			tone_q <= round_sum[MUL_P_W-1:28];
		end
		if (state_q == ST_MIX) begin
			res_q[ch_q] <= mix_sat;
		end
		if ((state_q == ST_OUT) && out_free) begin
			out_q     <= res_q;
			out_act_q <= mixed_q;
		end
	end

	assign item.ready         = (state_q == ST_IDLE);
	assign result.valid       = out_valid_q;
	assign result.audio_out_0 = out_q[0];
	assign result.audio_out_1 = out_q[1];
	assign result.audio_out_2 = out_q[2];
	assign result.audio_out_3 = out_q[3];
	assign result.tone_active = out_act_q;

	// A frame beat always keeps the block busy for at least the next cycle.
	a_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (item.cmd == rtm_pkg::CMD_FRAME)) |=> !item.ready)
		else $error("block ready right after a frame beat");

	// A result appears only out of the output state.
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == ST_OUT))
		else $error("result valid raised outside the output state");

	// The divider never runs past its last quotient bit.
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_cnt_q < rtm_pkg::DIV_CNT_W'(rtm_pkg::DIV_STEPS)))
		else $error("divider step count out of range");

	// The phase step is clamped away from zero.
	a_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != '0)
		else $error("phase step is zero");

endmodule

`default_nettype wire
